@@ hw/rtl/sqs_pkg.sv @@
// shared constants, types and codes for the sorted matrix quadrant search unit
package sqs_pkg;

  localparam int MAX_COLS    = 64;
  localparam int MAX_ROWS    = 64;
  localparam int STACK_DEPTH = 16;

  localparam int DATA_W    = 32;
  localparam int SIZE_W    = 7;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int CFG_IDX_W = 2;

  localparam int CX_W      = $clog2(MAX_COLS + 1);
  localparam int RY_W      = $clog2(MAX_ROWS + 1);
  localparam int ADDR_W    = $clog2(MAX_ROWS * MAX_COLS);
  localparam int STK_IDX_W = $clog2(STACK_DEPTH);
  localparam int STK_CNT_W = $clog2(STACK_DEPTH + 1);

  localparam logic [SIZE_W-1:0] NUM_COLS_RST = SIZE_W'(64);
  localparam logic [SIZE_W-1:0] NUM_ROWS_RST = SIZE_W'(64);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CX_W-1:0] sx;
    logic [RY_W-1:0] sy;
    logic [CX_W-1:0] ex;
    logic [RY_W-1:0] ey;
  } region_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_CMP,
    ST_FIN
  } state_t;

endpackage

@@ hw/rtl/sqs_store.sv @@
// matrix entry memory, one write and one registered read port
module sqs_store
  import sqs_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [MAX_ROWS*MAX_COLS];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/sqs_search.sv @@
// search sequencer: region stack, probe control and result register
module sqs_search
  import sqs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic                     in_op,
  input  logic [ROW_W-1:0]         in_row,
  input  logic [COL_W-1:0]         in_col,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [SIZE_W-1:0]        num_cols,
  input  logic [SIZE_W-1:0]        num_rows,
  output mem_req_t                 mem_req,
  input  logic [DATA_W-1:0]        rd_data,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic                     out_found
);

  state_t                   state_r, state_nxt;
  region_t                  stack_r [STACK_DEPTH];
  logic [STK_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  region_t                  reg_r, reg_nxt;
  logic [CX_W-1:0]          mx_r, mx_nxt;
  logic [RY_W-1:0]          my_r, my_nxt;
  logic                     hit_r, hit_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     found_r, found_nxt;

  region_t                  top, reg_a, reg_b;
  logic [CX_W:0]            sum_x;
  logic [RY_W:0]            sum_y;
  logic [CX_W-1:0]          mx_c, cols_c;
  logic [RY_W-1:0]          my_c, rows_c;
  logic                     push_a, push_b, push_init;
  logic [STK_CNT_W-1:0]     cnt_a, cnt_after;
  logic                     eq, lt;
  logic                     accept;

  assign accept = in_tvalid && in_tready;
  assign top    = stack_r[STK_IDX_W'(cnt_r - STK_CNT_W'(1))];
  assign sum_x  = {1'b0, top.sx} + {1'b0, top.ex};
  assign sum_y  = {1'b0, top.sy} + {1'b0, top.ey};
  assign mx_c   = CX_W'(sum_x >> 1);
  assign my_c   = RY_W'(sum_y >> 1);
  assign cols_c = (int'(num_cols) > MAX_COLS) ? CX_W'(MAX_COLS) : CX_W'(num_cols);
  assign rows_c = (int'(num_rows) > MAX_ROWS) ? RY_W'(MAX_ROWS) : RY_W'(num_rows);
  assign eq     = (rd_data == key_r);
  assign lt     = ($signed(rd_data) < key_r);

  // sub regions of the probed region
  always_comb begin
    if (lt) begin
      reg_a = '{sx: reg_r.sx, sy: my_r + RY_W'(1), ex: mx_r + CX_W'(1), ey: reg_r.ey};
      reg_b = '{sx: mx_r + CX_W'(1), sy: reg_r.sy, ex: reg_r.ex, ey: reg_r.ey};
    end else begin
      reg_a = '{sx: mx_r, sy: reg_r.sy, ex: reg_r.ex, ey: my_r};
      reg_b = '{sx: reg_r.sx, sy: reg_r.sy, ex: mx_r, ey: reg_r.ey};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    reg_nxt       = reg_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    push_init     = 1'b0;
    push_a        = (reg_a.sx < reg_a.ex) && (reg_a.sy < reg_a.ey) &&
                    (int'(cnt_r) < STACK_DEPTH);
    cnt_a         = cnt_r + STK_CNT_W'(push_a);
    push_b        = (reg_b.sx < reg_b.ex) && (reg_b.sy < reg_b.ey) &&
                    (int'(cnt_a) < STACK_DEPTH);
    cnt_after     = cnt_a + STK_CNT_W'(push_b);
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = ADDR_W'(in_row) * ADDR_W'(MAX_COLS) + ADDR_W'(in_col);
    mem_req.wr_data = in_value;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = ADDR_W'(my_c) * ADDR_W'(MAX_COLS) + ADDR_W'(mx_c);

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          if (in_op == OP_WRITE) begin
            mem_req.wr_en = (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);
          end else begin
            key_nxt   = in_value;
            hit_nxt   = 1'b0;
            push_init = (cols_c != '0) && (rows_c != '0);
            cnt_nxt   = STK_CNT_W'(push_init);
            state_nxt = ST_POP;
          end
        end
      end
      ST_POP: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r - STK_CNT_W'(1);
          reg_nxt = top;
          mx_nxt  = mx_c;
          my_nxt  = my_c;
          if ((int'(mx_c) < MAX_COLS) && (int'(my_c) < MAX_ROWS)) begin
            mem_req.rd_en = 1'b1;
            state_nxt     = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (eq) begin
          hit_nxt   = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt   = cnt_after;
          state_nxt = (cnt_after == '0) ? ST_FIN : ST_POP;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          found_nxt     = hit_r;
          cnt_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      key_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      key_r       <= key_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    reg_r   <= reg_nxt;
    mx_r    <= mx_nxt;
    my_r    <= my_nxt;
    found_r <= found_nxt;
    if (push_init) begin
      stack_r[0] <= '{sx: '0, sy: '0, ex: cols_c, ey: rows_c};
    end
    if ((state_r == ST_CMP) && !eq) begin
      if (push_a) begin
        stack_r[cnt_r[STK_IDX_W-1:0]] <= reg_a;
      end
      if (push_b) begin
        stack_r[cnt_a[STK_IDX_W-1:0]] <= reg_b;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_found  = found_r;

endmodule

@@ hw/rtl/sorted_matrix_quadrant_search_unit.sv @@
// top level of the sorted matrix quadrant search unit
//
//  channel  dir  handshake             payload
//  in_      in   in_tvalid/in_tready   tuser opcode, tdata row, col, value
//  out_     out  out_tvalid/out_tready tdata found
//  cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// a write transfer is taken in ST_IDLE; a search handles each probed region in
// ST_POP (stack pop and address) and then ST_CMP (memory read and compare), with a
// start and a finish around them, and probes no region for an empty matrix; this is
// bounded by the store's single read port
// rst_n is synchronous; the matrix store is not cleared, only control state
// a finished result waits in the output register while the next item is taken;
// a search that finishes before that result leaves holds in its last state

module sorted_matrix_quadrant_search_unit
  import sqs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_tuser,    // opcode
  input  logic [47:0]          in_tdata,    // row[5:0], col[11:6], value[43:12], zero pad
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,   // found[0], zero pad
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  logic [SIZE_W-1:0] num_cols_r, num_rows_r;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] rd_data;
  logic              found;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= NUM_COLS_RST;
      num_rows_r <= NUM_ROWS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_COLS: num_cols_r <= cfg_data;
        CFG_NUM_ROWS: num_rows_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sqs_search u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .in_row     (in_tdata[5:0]),
    .in_col     (in_tdata[11:6]),
    .in_value   ($signed(in_tdata[43:12])),
    .num_cols   (num_cols_r),
    .num_rows   (num_rows_r),
    .mem_req    (mem_req),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_found  (found)
  );

  sqs_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign out_tdata = {7'b0, found};

endmodule

@@ hw/rtl/sqs_checker.sv @@
// port level checks for the sorted matrix quadrant search unit
module sqs_checker
  import sqs_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 in_tuser,
  input logic [47:0]          in_tdata,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [7:0]           out_tdata,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [SIZE_W-1:0]    cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && in_tvalid && in_tready && (in_tuser == OP_WRITE) |=> !out_tvalid)
    else $error("write transfer produced a result");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:1] == 7'b0))
    else $error("result padding not zero");

endmodule

bind sorted_matrix_quadrant_search_unit sqs_checker u_sqs_checker (.*);

@@ verif/sqs_result_checker.sv @@
// checker that predicts and compares found flags of the sorted matrix quadrant search unit
module sqs_result_checker
  import sqs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic                 in_tuser,    // opcode
  input  logic [47:0]          in_tdata,    // row[5:0], col[11:6], value[43:12], zero pad
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [7:0]           out_tdata,   // found[0], zero pad
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [SIZE_W-1:0] x0;
    logic [SIZE_W-1:0] y0;
    logic [SIZE_W-1:0] x1;
    logic [SIZE_W-1:0] y1;
  } span_t;

  logic [DATA_W-1:0] cell_q [MAX_ROWS*MAX_COLS];
  logic [SIZE_W-1:0] cols_q;
  logic [SIZE_W-1:0] rows_q;
  span_t             span_stack [STACK_DEPTH];
  int                span_depth;
  logic              found_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    cols_q     = NUM_COLS_RST;
    rows_q     = NUM_ROWS_RST;
    span_depth = 0;
  end

  function automatic void push_span(input logic [SIZE_W-1:0] x0, input logic [SIZE_W-1:0] y0,
                                    input logic [SIZE_W-1:0] x1, input logic [SIZE_W-1:0] y1);
    if (x0 >= x1 || y0 >= y1) return;
    // full stack drops the region
    if (span_depth >= STACK_DEPTH) return;
    span_stack[span_depth] = '{x0: x0, y0: y0, x1: x1, y1: y1};
    span_depth++;
  endfunction

  function automatic logic predict_found(input logic [DATA_W-1:0] key);
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic [SIZE_W-1:0] mx;
    logic [SIZE_W-1:0] my;
    logic [DATA_W-1:0] e;
    span_t             s;
    logic              hit;
    w = (cols_q > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : cols_q;
    h = (rows_q > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_q;
    hit = 1'b0;
    span_depth = 0;
    push_span('0, '0, w, h);
    while (span_depth > 0 && !hit) begin
      span_depth--;
      s  = span_stack[span_depth];
      mx = SIZE_W'(({1'b0, s.x0} + {1'b0, s.x1}) >> 1);
      my = SIZE_W'(({1'b0, s.y0} + {1'b0, s.y1}) >> 1);
      if (mx >= MAX_COLS || my >= MAX_ROWS) continue;
      e = cell_q[int'(my) * MAX_COLS + int'(mx)];
      if (e == key) begin
        hit = 1'b1;
      end else if ($signed(e) < $signed(key)) begin
        push_span(s.x0, my + 1'b1, mx + 1'b1, s.y1);
        push_span(mx + 1'b1, s.y0, s.x1, s.y1);
      end else begin
        push_span(mx, s.y0, s.x1, my);
        push_span(s.x0, s.y0, mx, s.y1);
      end
    end
    span_depth = 0;
    return hit;
  endfunction

  always @(posedge clk) begin : watch
    logic              exp_found;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DATA_W-1:0] value;
    if (!rst_n) begin
      cols_q = NUM_COLS_RST;
      rows_q = NUM_ROWS_RST;
      found_q.delete();
      pending = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (found_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual found=%0b",
                   $time, out_tdata[0]);
          fail_count++;
        end else begin
          exp_found = found_q.pop_front();
          if (out_tdata[0] !== exp_found) begin
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $time, exp_found, out_tdata[0]);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NUM_COLS: cols_q = cfg_data;
          CFG_NUM_ROWS: rows_q = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        row   = in_tdata[0 +: ROW_W];
        col   = in_tdata[ROW_W +: COL_W];
        value = in_tdata[ROW_W+COL_W +: DATA_W];
        if (in_tuser == OP_SEARCH) begin
          found_q.push_back(predict_found(value));
        end else begin
          cell_q[int'(row) * MAX_COLS + int'(col)] = value;
        end
      end
      pending = found_q.size();
    end
  end

endmodule

@@ verif/tb_sorted_matrix_quadrant_search_unit.sv @@
// testbench top for the sorted matrix quadrant search unit: stimulus and verdict
module tb_sorted_matrix_quadrant_search_unit;
  import sqs_pkg::*;

  localparam int CYCLE_LIMIT  = 20_000_000;
  localparam int IDLE_GAP     = 8;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 700;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  localparam logic [DATA_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] KEY_MAX = 32'h7fff_ffff;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic                 in_tuser;
  logic [47:0]          in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  int fail_count;
  int pending;
  int cycles = 0;
  int sent_items;
  int out_hold = 0;
  bit calm;

  logic signed [DATA_W-1:0] mat [MAX_ROWS][MAX_COLS];
  logic [SIZE_W-1:0]        cur_cols;
  logic [SIZE_W-1:0]        cur_rows;

  sorted_matrix_quadrant_search_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sqs_result_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int eff_size(input logic [SIZE_W-1:0] v, input int limit);
    return (int'(v) > limit) ? limit : int'(v);
  endfunction

  // result side stalls
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_hold > 0) begin
        out_tready <= 1'b0;
        out_hold--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 2) == 0) out_hold = pick_gap();
      end
    end
  end

  task automatic send_item(input logic op, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col, input logic [DATA_W-1:0] val);
    int gap;
    in_tuser  <= op;
    in_tdata  <= {4'b0, val, col, row};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_WRITE) mat[row][col] = val;
    sent_items++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic search(input logic [DATA_W-1:0] key);
    send_item(OP_SEARCH, ROW_W'($urandom), COL_W'($urandom), key);
  endtask

  task automatic write_cell(input int r, input int c, input logic [DATA_W-1:0] v);
    send_item(OP_WRITE, ROW_W'(r), COL_W'(c), v);
  endtask

  // wait until every search has answered and any write has drained
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    settle();
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_NUM_COLS) cur_cols = data;
    else if (idx == CFG_NUM_ROWS) cur_rows = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // rows and columns ascending, saturating at the top of the signed range
  task automatic fill_sorted(input int rows, input int cols, input int step_max);
    longint base;
    longint v;
    longint left;
    case ($urandom_range(0, 3))
      0:       base = -64'sd2147483648 + longint'($urandom_range(0, 1000));
      1:       base = longint'(int'($urandom));
      2:       base = 64'sd2147483647 - longint'($urandom_range(0, 100000));
      default: base = longint'($urandom_range(0, 200)) - 100;
    endcase
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if (r == 0 && c == 0) begin
          v = base;
        end else begin
          v = (r > 0) ? longint'(mat[r-1][c]) : -64'sd2147483648;
          if (c > 0) begin
            left = longint'(mat[r][c-1]);
            if (left > v) v = left;
          end
          v = v + longint'($urandom_range(0, step_max));
        end
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        write_cell(r, c, v[DATA_W-1:0]);
      end
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_key(input int rows, input int cols);
    int r;
    int pr;
    int pc;
    if (rows == 0 || cols == 0) return $urandom;
    r  = $urandom_range(0, 99);
    pr = $urandom_range(0, rows - 1);
    pc = $urandom_range(0, cols - 1);
    if (r < 40) return mat[pr][pc];
    if (r < 50) return mat[pr][pc] + 1;
    if (r < 60) return mat[pr][pc] - 1;
    if (r < 80) return $urandom;
    if (r < 85) return KEY_MIN;
    if (r < 90) return KEY_MAX;
    if (r < 95) return mat[0][0];
    return mat[rows-1][cols-1];
  endfunction

  function automatic int pick_step();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 1;
      2:       return 16;
      3:       return 1024;
      4:       return 1 << 20;
      default: return 1 << 25;
    endcase
  endfunction

  initial begin
    int base_items;
    int k;
    int n;
    int er;
    int ec;
    bit refill;
    logic [SIZE_W-1:0] nc;
    logic [SIZE_W-1:0] nr;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    calm       = 1'b0;
    sent_items = 0;
    cur_cols   = NUM_COLS_RST;
    cur_rows   = NUM_ROWS_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty matrix, nothing is read
    set_reg(CFG_NUM_COLS, SIZE_W'(0));
    search('0);
    search(KEY_MIN);
    set_reg(CFG_NUM_COLS, SIZE_W'(64));
    set_reg(CFG_NUM_ROWS, SIZE_W'(0));
    search(KEY_MAX);
    set_reg(CFG_SPARE_A, SIZE_W'(1));
    set_reg(CFG_SPARE_B, SIZE_W'(127));
    set_reg(CFG_NUM_ROWS, SIZE_W'(64));

    calm = 1'b1;
    fill_sorted(MAX_ROWS, MAX_COLS, 1 << 19);
    calm = 1'b0;

    search(mat[0][0]);
    search(mat[63][63]);
    search(mat[31][17]);
    search(mat[31][17] + 1);
    search(KEY_MIN);
    search(KEY_MAX);
    search('0);
    // oversize registers act as the full store
    set_reg(CFG_NUM_COLS, SIZE_W'(127));
    set_reg(CFG_NUM_ROWS, SIZE_W'(100));
    search(mat[63][63]);
    search(mat[5][60]);
    set_reg(CFG_NUM_COLS, SIZE_W'(1));
    set_reg(CFG_NUM_ROWS, SIZE_W'(1));
    search(mat[0][0]);
    search(mat[0][1]);
    // entry outside the used size
    write_cell(40, 40, 32'h5a5a_a5a5);
    search(32'h5a5a_a5a5);
    set_reg(CFG_NUM_COLS, SIZE_W'(64));
    set_reg(CFG_NUM_ROWS, SIZE_W'(64));
    search(32'h5a5a_a5a5);

    base_items = sent_items;
    while (sent_items - base_items < RANDOM_ITEMS) begin
      k = $urandom_range(0, 99);
      refill = 1'b1;
      if (k < 80) begin
        nc = SIZE_W'($urandom_range(1, 10));
        nr = SIZE_W'($urandom_range(1, 10));
      end else if (k < 90) begin
        nc = SIZE_W'($urandom_range(11, 20));
        nr = SIZE_W'($urandom_range(11, 20));
      end else if (k < 95) begin
        refill = 1'b0;
        if ($urandom_range(0, 1) == 0) begin
          nc = '0;
          nr = SIZE_W'($urandom_range(0, 127));
        end else begin
          nc = SIZE_W'($urandom_range(0, 127));
          nr = '0;
        end
      end else begin
        refill = 1'b0;
        nc = ($urandom_range(0, 1) == 0) ? SIZE_W'(64) : SIZE_W'($urandom_range(65, 127));
        nr = ($urandom_range(0, 1) == 0) ? SIZE_W'(64) : SIZE_W'($urandom_range(65, 127));
      end
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        set_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B, SIZE_W'($urandom));
      end
      set_reg(CFG_NUM_COLS, nc);
      set_reg(CFG_NUM_ROWS, nr);
      er = eff_size(cur_rows, MAX_ROWS);
      ec = eff_size(cur_cols, MAX_COLS);
      if (refill) fill_sorted(er, ec, pick_step());
      n = $urandom_range(8, 24);
      repeat (n) begin
        k = $urandom_range(0, 99);
        if (k < 80) begin
          search(pick_key(er, ec));
        end else begin
          write_cell($urandom_range(0, MAX_ROWS - 1), $urandom_range(0, MAX_COLS - 1), $urandom);
        end
      end
    end
    calm = 1'b0;

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
